/* design/skf_pkg.sv */
// Package for the scalar Kalman filter: sequencer states, register indexes
// and fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package skf_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned FracW  = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned QuoW   = FracW + 1;

  localparam logic [CfgIdxW-1:0] RegProcessNoise     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegMeasurementNoise = CfgIdxW'(1);

  localparam logic [DataW-1:0] ProcessNoiseRst     = DataW'(655);
  localparam logic [DataW-1:0] MeasurementNoiseRst = DataW'(65536);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_MULE,
    ST_MULC,
    ST_FIN
  } skf_state_e;

endpackage

/* design/scalar_kalman_filter.sv */
// Scalar Kalman filter top level: sequencer, restoring divider and one shared
// multiplier. Depends on skf_pkg.
`timescale 1ns / 1ps

// One sample in, one (estimate, covariance) pair out. The prediction and the
// difference are registered at the transfer itself. Then come the step for the
// gain denominator, the restoring divider that forms the gain one quotient bit
// a cycle, the shared 33x17 multiplier (estimate step, then covariance) and the
// write-back step. The input is stalled for that time, so a new sample is taken
// only after the last one has been written back. A finished result waits in the
// output register and the next sample is taken while it waits. If the previous
// result has still not been taken when a new one is ready, the block holds in
// its final step. Configuration writes are always ready and should only be
// issued while the block is idle.
module scalar_kalman_filter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [31:0]           sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [31:0]           estimate_o,
  output logic        [31:0]           covariance_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [skf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [skf_pkg::DataW-1:0]    cfg_data_i
);
  import skf_pkg::*;

  skf_state_e state_q, state_d;
  logic [4:0] cnt_q;

  logic [DataW-1:0]        qn_q, rn_q;
  logic signed [DataW-1:0] est_q;
  logic [DataW-1:0]        cov_q;
  logic                    out_valid_q;
  logic signed [DataW-1:0] out_est_q;
  logic [DataW-1:0]        out_cov_q;

  logic [DataW-1:0]   pred_q;
  logic [DataW:0]     sum_q;
  logic [DataW+1:0]   rem_q;
  logic [QuoW-1:0]    quo_q;
  logic [DataW:0]     mag_q;
  logic               neg_q;
  logic [2*DataW+1:0] prod_q;
  logic [DataW:0]     step_q;

  logic               in_acc, out_acc, fin_go;
  logic [DataW:0]     pred_sum;
  logic [DataW-1:0]   pred_new;
  logic signed [DataW:0] diff;
  logic [DataW+1:0]   trial;
  logic               q_bit;
  logic [FracW-1:0]   gain;
  logic [DataW:0]     mul_a;
  logic [QuoW-1:0]    mul_b;
  logic [2*DataW+1:0] prod_rnd;
  logic [DataW+1:0]   est_new;
  logic [DataW-1:0]   cov_new;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign fin_go      = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;

  assign pred_sum = {1'b0, cov_q} + {1'b0, qn_q};
  assign pred_new = pred_sum[DataW] ? '1 : pred_sum[DataW-1:0];
  assign diff     = {sample_i[DataW-1], sample_i} - {est_q[DataW-1], est_q};

  assign trial = (cnt_q == 5'd0) ? rem_q : {rem_q[DataW:0], 1'b0};
  assign q_bit = trial >= {1'b0, sum_q};

  always_comb begin
    if (sum_q == '0) begin
      gain = '0;
    end else if (quo_q[QuoW-1]) begin
      gain = '1;
    end else begin
      gain = quo_q[FracW-1:0];
    end
  end

  // Shared multiplier: estimate step, then covariance scaling
  always_comb begin
    if (state_q == ST_MULE) begin
      mul_a = mag_q;
      mul_b = {1'b0, gain};
    end else begin
      mul_a = {1'b0, pred_q};
      mul_b = (QuoW'(1) << FracW) - {1'b0, gain};
    end
  end

  assign prod_rnd = prod_q + ((2*DataW+2)'(1) << (FracW - 1));
  assign cov_new  = prod_rnd[FracW +: DataW];
  assign est_new  = neg_q ? ({{2{est_q[DataW-1]}}, est_q} - {1'b0, step_q})
                          : ({{2{est_q[DataW-1]}}, est_q} + {1'b0, step_q});

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) state_d = ST_SUM;
      end
      ST_SUM:  state_d = ST_DIV;
      ST_DIV:  if (cnt_q == 5'(FracW)) state_d = ST_MULE;
      ST_MULE: state_d = ST_MULC;
      ST_MULC: state_d = ST_FIN;
      ST_FIN:  if (fin_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      qn_q        <= ProcessNoiseRst;
      rn_q        <= MeasurementNoiseRst;
      est_q       <= '0;
      cov_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DIV) begin
        cnt_q <= cnt_q + 5'd1;
      end else begin
        cnt_q <= '0;
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == RegProcessNoise)     qn_q <= cfg_data_i;
        if (cfg_index_i == RegMeasurementNoise) rn_q <= cfg_data_i;
      end
      if (fin_go) begin
        est_q       <= est_new[DataW-1:0];
        cov_q       <= cov_new;
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pred_q <= pred_new;
      neg_q  <= diff[DataW];
      mag_q  <= diff[DataW] ? (DataW+1)'(0) - diff : diff;
    end
    if (state_q == ST_SUM) begin
      sum_q <= {1'b0, pred_q} + {1'b0, rn_q};
      rem_q <= {2'b00, pred_q};
    end
    if (state_q == ST_DIV) begin
      rem_q <= q_bit ? trial - {1'b0, sum_q} : trial;
      quo_q <= {quo_q[QuoW-2:0], q_bit};
    end
    if (state_q == ST_MULE || state_q == ST_MULC) begin
      prod_q <= (2*DataW+2)'(mul_a * mul_b);
    end
    if (state_q == ST_MULC) begin
      step_q <= prod_rnd[FracW +: DataW+1];
    end
    if (fin_go) begin
      out_est_q <= est_new[DataW-1:0];
      out_cov_q <= cov_new;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign estimate_o   = out_est_q;
  assign covariance_o = out_cov_q;

  a_rose_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result presented outside the write-back step");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |=> (state_q == ST_DIV) && (cnt_q == 5'd0))
    else $error("divider did not start from its first quotient bit");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q <= 5'(FracW)))
    else $error("divider ran past its last quotient bit");

  a_cov_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |-> (cov_new <= pred_q))
    else $error("updated covariance exceeds the prediction");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_SUM) && in_stall_o)
    else $error("input taken while a sample was being processed");

endmodule

/* tb/testbench.sv */
// Self-checking bench for scalar_kalman_filter: a scoreboard class predicts each
// (estimate, covariance) pair from the accepted samples and the noise registers.
// Depends on skf_pkg and the filter RTL.
`timescale 1ns / 1ps

typedef struct {
  logic signed [31:0] estimate;
  logic        [31:0] covariance;
} kalman_pair_t;

class kalman_scoreboard;
  logic        [31:0] proc_noise;
  logic        [31:0] meas_noise;
  logic signed [31:0] est_state;
  logic        [31:0] cov_state;
  kalman_pair_t       expected_pairs[$];
  int                 mismatches;
  int                 samples_taken;
  int                 pairs_checked;

  function new();
    proc_noise    = skf_pkg::ProcessNoiseRst;
    meas_noise    = skf_pkg::MeasurementNoiseRst;
    est_state     = '0;
    cov_state     = '0;
    mismatches    = 0;
    samples_taken = 0;
    pairs_checked = 0;
  endfunction

  function void set_reg(logic [skf_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    if (idx == skf_pkg::RegProcessNoise) proc_noise = val;
    else if (idx == skf_pkg::RegMeasurementNoise) meas_noise = val;
  endfunction

  // One filter step on the accepted sample; queues the pair the block must return.
  function void take_sample(logic signed [31:0] smp);
    logic [32:0]  pred;
    logic [32:0]  total;
    logic [63:0]  gain;
    logic [63:0]  mag;
    logic [63:0]  stepv;
    logic [63:0]  new_cov;
    longint       diff;
    longint       new_est;
    kalman_pair_t pair;
    pred = {1'b0, cov_state} + {1'b0, proc_noise};
    if (pred[32]) pred = 33'h0_FFFF_FFFF;
    total = pred + {1'b0, meas_noise};
    if (total == '0) begin
      gain = '0;
    end else begin
      gain = ({31'b0, pred} << 16) / {31'b0, total};
      if (gain > 64'hFFFF) gain = 64'hFFFF;
    end
    diff = longint'(smp) - longint'(est_state);
    if (diff < 0) mag = 64'(-diff);
    else mag = 64'(diff);
    stepv = (mag * gain + 64'd32768) >> 16;
    if (diff < 0) new_est = longint'(est_state) - longint'(stepv);
    else new_est = longint'(est_state) + longint'(stepv);
    new_cov = ((64'd65536 - gain) * {31'b0, pred} + 64'd32768) >> 16;
    if (new_cov > 64'hFFFF_FFFF) new_cov = 64'hFFFF_FFFF;
    est_state = new_est[31:0];
    cov_state = new_cov[31:0];
    pair.estimate   = est_state;
    pair.covariance = cov_state;
    expected_pairs.push_back(pair);
    samples_taken++;
  endfunction

  function void check_pair(logic signed [31:0] est, logic [31:0] cov);
    kalman_pair_t want;
    if (expected_pairs.size() == 0) begin
      $display("%0t: unexpected result estimate %h covariance %h", $time, est, cov);
      mismatches++;
    end else begin
      want = expected_pairs.pop_front();
      pairs_checked++;
      if (est !== want.estimate) begin
        $display("%0t: estimate expected %h actual %h", $time, want.estimate, est);
        mismatches++;
      end
      if (cov !== want.covariance) begin
        $display("%0t: covariance expected %h actual %h", $time, want.covariance, cov);
        mismatches++;
      end
    end
  endfunction

  function int pending();
    return expected_pairs.size();
  endfunction

  function void close();
    if (expected_pairs.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_pairs.size());
      mismatches += expected_pairs.size();
    end
  endfunction
endclass

module testbench;
  import skf_pkg::*;

  localparam int unsigned RandPhases    = 10;
  localparam int unsigned ItemsPerPhase = 155;
  localparam int unsigned DrainCycles   = 40;
  localparam logic [CfgIdxW-1:0] RegFirstUnused = RegMeasurementNoise + CfgIdxW'(1);

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] sample_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] estimate_o;
  logic        [31:0] covariance_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [DataW-1:0]   cfg_data_i;

  kalman_scoreboard sb;
  int               src_idle_pct;
  int               sink_idle_pct;
  int               hold_cycles;
  int               reg_writes;
  int               settings_run;

  scalar_kalman_filter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .estimate_o   (estimate_o),
    .covariance_o (covariance_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sink side: random stall, or a long hold-off while hold_cycles runs down.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(99) < sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_pair(estimate_o, covariance_o);
  end

  // Entered and left at a falling edge; valid stays high after the transfer.
  task automatic send_sample(input logic signed [31:0] smp);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_sample(smp);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_noise(input logic [31:0] q, input logic [31:0] r);
    write_reg(RegProcessNoise, q);
    write_reg(RegMeasurementNoise, r);
    settings_run++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_noise();
    logic [31:0] v;
    case ($urandom_range(6))
      0: v = '0;
      1: v = 32'hFFFF_FFFF;
      2: v = $urandom_range(2000);
      3: v = $urandom_range(32'h0010_0000);
      4: v = 32'h0001_0000 * $urandom_range(1, 64);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] pick_sample();
    logic signed [31:0] v;
    case ($urandom_range(9))
      0: v = 32'sh7FFF_FFFF;
      1: v = 32'sh8000_0000;
      2, 3: v = 32'(int'($urandom_range(32'h0020_0000)) - int'(32'h0010_0000));
      4: v = sb.est_state + 32'(int'($urandom_range(64)) - 32);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    sample_i      = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    src_idle_pct  = 12;
    sink_idle_pct = 55;
    hold_cycles   = 0;
    reg_writes    = 0;
    settings_run  = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset noise values, sample extremes and the widest possible difference.
    send_sample(32'sh0000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(-32'sd1);
    send_sample(32'sd1);
    drain();

    // Out-of-range index must leave both registers alone.
    write_reg(RegFirstUnused, $urandom);
    write_reg(CfgIdxW'($urandom_range(255, RegFirstUnused)), $urandom);
    send_sample(32'sh0001_8000);
    drain();

    // No noise at all: unity gain saturates, covariance collapses, then zero sum.
    set_noise('0, '0);
    send_sample(32'sh8000_0000);
    send_sample(32'sd12345);
    send_sample(32'sh7FFF_FFFF);
    send_sample(-32'sd5);
    send_sample(32'sd0);
    drain();

    // Full-scale noise: predicted covariance saturates.
    set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (3) send_sample($urandom);
    drain();
    set_noise(32'hFFFF_FFFF, '0);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample($urandom);
    drain();
    set_noise('0, 32'hFFFF_FFFF);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    drain();

    for (int ph = 0; ph < RandPhases; ph++) begin
      if (ph < 4) begin
        src_idle_pct  = 12;
        sink_idle_pct = 55;
      end else if (ph < 7) begin
        src_idle_pct  = 55;
        sink_idle_pct = 12;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (ph % 3 == 2) write_reg(CfgIdxW'($urandom_range(255, RegFirstUnused)), $urandom);
      set_noise(pick_noise(), pick_noise());
      if (ph == 1) hold_cycles = 500;
      for (int i = 0; i < ItemsPerPhase; i++) send_sample(pick_sample());
      drain();
    end

    sb.close();
    $display("%0d samples sent, %0d results checked", sb.samples_taken, sb.pairs_checked);
    $display("%0d register writes across %0d noise settings", reg_writes, settings_run);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
